// ===== rtl/chr_pkg.sv =====
`default_nettype none

package chr_pkg;

    // verdict reason codes
    localparam int unsigned REASON_W = 3;
    typedef logic [REASON_W-1:0] t_reason;

    localparam t_reason REASON_OK     = 3'd0;
    localparam t_reason REASON_SHORT  = 3'd1;
    localparam t_reason REASON_META   = 3'd2;
    localparam t_reason REASON_ATTR   = 3'd3;
    localparam t_reason REASON_MARKER = 3'd4;
    localparam t_reason REASON_DEVICE = 3'd5;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_DEVICE_ID      = 1'd0;
    localparam t_cfg_idx CFG_DEVICE_PRESENT = 1'd1;

    localparam int unsigned CFG_DATA_W = 60;

    // fifteen-byte type marker, text "x-" + vendor + "-teh-rtp"
    function automatic logic [7:0] marker_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h78;
            4'd1:    b = 8'h2D;
            4'd2:    b = 8'h6E;
            4'd3:    b = 8'h6F;
            4'd4:    b = 8'h6B;
            4'd5:    b = 8'h69;
            4'd6:    b = 8'h61;
            4'd7:    b = 8'h2D;
            4'd8:    b = 8'h74;
            4'd9:    b = 8'h65;
            4'd10:   b = 8'h68;
            4'd11:   b = 8'h2D;
            4'd12:   b = 8'h72;
            4'd13:   b = 8'h74;
            4'd14:   b = 8'h70;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/clip_header_recognizer.sv =====
// Clip header recogniser. Header bytes enter on the input channel one item per
// clock while o_stall is low, offset zero first; the item flagged i_last_byte
// closes the header and yields one registered verdict item (o_recognized,
// o_reason), then the byte position returns to zero for the next header. A
// byte is taken in the cycle it is offered unless o_stall is high, so the
// sustained rate is one item per clock while the output side takes verdicts.
// The start/end timing check runs in the background on a small divider that
// is launched once the duration field (offset 51) has arrived; a header needs
// 36 more bytes before its verdict can depend on it, so the check is always
// complete in time. Verdicts pass through a result register and a one-entry
// skid register: o_stall only rises when both hold a verdict, i.e. after the
// output side has stalled while a second verdict came in. The device id
// registers may be written only while no header is in flight.

`default_nettype none

module clip_header_recognizer (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // header byte channel
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  [7:0]                       i_header_byte,
    input  wire                              i_last_byte,
    // verdict channel
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic                             o_recognized,
    output chr_pkg::t_reason                 o_reason,
    // configuration
    input  wire                              i_cfg_we,
    input  wire  chr_pkg::t_cfg_idx          i_cfg_index,
    input  wire  [chr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import chr_pkg::*;

    // header layout
    localparam logic [6:0] HDR_NEEDED    = 7'd88;
    localparam logic [6:0] POS_META0     = 7'd0;
    localparam logic [6:0] POS_META1     = 7'd1;
    localparam logic [6:0] POS_META2     = 7'd2;
    localparam logic [6:0] POS_DUR_LAST  = 7'd51;
    localparam logic [6:0] POS_MARK_LEN  = 7'd56;
    localparam logic [6:0] POS_MARK_0    = 7'd57;
    localparam logic [6:0] POS_DEV_LEN   = 7'd72;
    localparam logic [6:0] POS_DEV_0     = 7'd73;
    localparam logic [7:0] FIELD_LEN     = 8'd15;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;

    // timing limits
    localparam logic [63:0] MILLENNIUM_MS  = 64'd63072000000000;
    localparam logic [31:0] MAX_DURATION   = 32'd86400000;
    localparam logic [31:0] MAX_DUR_ERROR  = 32'd60000;
    localparam logic [10:0] MS_PER_US      = 11'd1000;

    // timing sequencer steps
    localparam logic [4:0] TM_IDLE     = 5'd0;
    localparam logic [4:0] TM_PREP     = 5'd1;
    localparam logic [4:0] TM_DIV_LAST = 5'd17;
    localparam logic [4:0] TM_FINAL    = 5'd18;

    // ---------------------------------------------------------------- config
    logic [CFG_DATA_W-1:0] r_dev_digits;
    logic                  r_dev_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_digits  <= '0;
            r_dev_present <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEVICE_ID:      r_dev_digits  <= i_cfg_data;
                CFG_DEVICE_PRESENT: r_dev_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- header state
    logic        in_acc;
    logic        take;
    logic        clear;

    logic [6:0]  r_pos,        n_pos;
    logic        r_meta_ok,    n_meta_ok;
    logic [31:0] r_attr,       n_attr;
    logic        r_mk_len_ok,  n_mk_len_ok;
    logic        r_mk_match,   n_mk_match;
    logic        r_dev_len_ok, n_dev_len_ok;
    logic        r_dev_match,  n_dev_match;

    logic [63:0] r_start;
    logic [63:0] r_end;
    logic [31:0] r_dur;

    logic [3:0]  mk_idx;
    logic [3:0]  dev_idx;
    logic [3:0]  dev_nib_sel;
    logic [3:0]  dev_nib;
    logic [2:0]  time_lane;

    assign in_acc = i_valid & ~o_stall;
    assign take   = (r_pos < HDR_NEEDED);
    assign clear  = in_acc & i_last_byte;

    assign mk_idx      = 4'(r_pos - POS_MARK_0);
    assign dev_idx     = 4'(r_pos - POS_DEV_0);
    assign dev_nib_sel = 4'(4'd14 - dev_idx);
    assign dev_nib     = r_dev_digits[{dev_nib_sel, 2'b00} +: 4];
    // low word first, each word big-endian
    assign time_lane   = {r_pos[2], ~r_pos[1:0]};

    // header state as it stands once the current byte is folded in
    always_comb begin
        n_pos        = r_pos;
        n_meta_ok    = r_meta_ok;
        n_attr       = r_attr;
        n_mk_len_ok  = r_mk_len_ok;
        n_mk_match   = r_mk_match;
        n_dev_len_ok = r_dev_len_ok;
        n_dev_match  = r_dev_match;
        if (take) begin
            n_pos = r_pos + 7'd1;
            if (r_pos == POS_META0) begin
                n_meta_ok = (i_header_byte == 8'd0);
            end else if (r_pos == POS_META1) begin
                n_meta_ok = r_meta_ok & (i_header_byte == 8'd0);
            end else if (r_pos == POS_META2) begin
                n_meta_ok = r_meta_ok & (i_header_byte < 8'd8);
            end else if (r_pos[6:2] == 5'd1) begin
                n_attr = {r_attr[23:0], i_header_byte};
            end else if (r_pos == POS_MARK_LEN) begin
                n_mk_len_ok = (i_header_byte == FIELD_LEN);
            end else if (r_pos >= POS_MARK_0 && r_pos < POS_DEV_LEN) begin
                if (i_header_byte != marker_byte(mk_idx)) begin
                    n_mk_match = 1'b0;
                end
            end else if (r_pos == POS_DEV_LEN) begin
                n_dev_len_ok = (i_header_byte == FIELD_LEN);
            end else if (r_pos >= POS_DEV_0) begin
                // a digit nibble above nine never matches
                if (dev_nib > 4'd9 || i_header_byte != (ASCII_ZERO + {4'd0, dev_nib})) begin
                    n_dev_match = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_pos        <= '0;
            r_meta_ok    <= 1'b0;
            r_mk_len_ok  <= 1'b0;
            r_mk_match   <= 1'b1;
            r_dev_len_ok <= 1'b0;
            r_dev_match  <= 1'b1;
        end else if (in_acc) begin
            r_pos        <= n_pos;
            r_meta_ok    <= n_meta_ok;
            r_mk_len_ok  <= n_mk_len_ok;
            r_mk_match   <= n_mk_match;
            r_dev_len_ok <= n_dev_len_ok;
            r_dev_match  <= n_dev_match;
        end
    end

    // wide fields, fully rewritten by every header before they are used
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_attr <= n_attr;
            if (take) begin
                if (r_pos[6:3] == 4'd4) begin
                    r_start[{time_lane, 3'b000} +: 8] <= i_header_byte;
                end
                if (r_pos[6:3] == 4'd5) begin
                    r_end[{time_lane, 3'b000} +: 8] <= i_header_byte;
                end
                if (r_pos[6:2] == 5'd12) begin
                    r_dur <= {r_dur[23:0], i_header_byte};
                end
            end
        end
    end

    // ---------------------------------------------------------- timing check
    // prep: sign of the span, magnitude, range checks; then 16 steps of four
    // restoring-division bits (divide by 1000, keep the low 32 quotient
    // bits); final: apply the sign and compare against the duration
    logic [4:0]  r_tm_step, n_tm_step;
    logic        r_timing_ok;
    logic        r_neg;
    logic [63:0] r_mag;
    logic        r_range_ok;
    logic        r_dur_ok;
    logic [31:0] r_thr;
    logic [9:0]  r_rem;
    logic [31:0] r_quo;

    logic        tm_start;
    logic        end_before;
    logic [9:0]  div_rem;
    logic [10:0] div_t;
    logic [3:0]  div_q;
    logic [31:0] span;
    logic        final_ok;

    assign tm_start   = in_acc & ~i_last_byte & (r_pos == POS_DUR_LAST);
    assign end_before = (r_end < r_start);

    always_comb begin
        div_rem = r_rem;
        div_t   = '0;
        div_q   = '0;
        for (int k = 0; k < 4; k++) begin
            div_t = {div_rem, r_mag[6'(63 - k)]};
            if (div_t >= MS_PER_US) begin
                div_rem          = 10'(div_t - MS_PER_US);
                div_q[2'(3 - k)] = 1'b1;
            end else begin
                div_rem = div_t[9:0];
            end
        end
    end

    assign span     = r_neg ? (~r_quo + 32'd1) : r_quo;
    assign final_ok = r_range_ok & r_dur_ok & (span != 32'd0) & ~span[31] & (span > r_thr);

    always_comb begin
        n_tm_step = r_tm_step;
        if (tm_start) begin
            n_tm_step = TM_PREP;
        end else if (r_tm_step == TM_FINAL) begin
            n_tm_step = TM_IDLE;
        end else if (r_tm_step != TM_IDLE) begin
            n_tm_step = r_tm_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_tm_step   <= TM_IDLE;
            r_timing_ok <= 1'b0;
        end else begin
            r_tm_step <= n_tm_step;
            if (r_tm_step == TM_FINAL) begin
                r_timing_ok <= final_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tm_step == TM_PREP) begin
            r_neg      <= end_before;
            r_mag      <= end_before ? (r_start - r_end) : (r_end - r_start);
            r_range_ok <= ~r_start[63] & (r_start > MILLENNIUM_MS) &
                          ~r_end[63]   & (r_end   > MILLENNIUM_MS);
            r_dur_ok   <= (r_dur < MAX_DURATION);
            r_thr      <= (r_dur > MAX_DUR_ERROR) ? (r_dur - MAX_DUR_ERROR) : 32'd0;
            r_rem      <= '0;
            r_quo      <= '0;
        end else if (r_tm_step > TM_PREP && r_tm_step <= TM_DIV_LAST) begin
            r_mag <= {r_mag[59:0], 4'd0};
            r_rem <= div_rem;
            r_quo <= {r_quo[27:0], div_q};
        end
    end

    // --------------------------------------------------------------- verdict
    t_reason    verdict;
    logic [3:0] ver_nib;
    logic [7:0] post_rule;

    assign ver_nib   = n_attr[7:4];
    assign post_rule = n_attr[23:16];

    always_comb begin
        if (n_pos < HDR_NEEDED) begin
            verdict = REASON_SHORT;
        end else if (!n_meta_ok) begin
            verdict = REASON_META;
        end else if (post_rule > 8'd3 || ver_nib < 4'd2 || ver_nib > 4'd8) begin
            verdict = REASON_ATTR;
        end else if (!n_mk_len_ok) begin
            verdict = REASON_MARKER;
        end else if (!n_mk_match && !r_timing_ok) begin
            // marker text differs: the timing check has the last word
            verdict = REASON_MARKER;
        end else if (post_rule == 8'd2 &&
                     (!r_dev_present || !n_dev_len_ok || !n_dev_match)) begin
            verdict = REASON_DEVICE;
        end else begin
            verdict = REASON_OK;
        end
    end

    // ------------------------------------------------- result and skid regs
    logic    r_out_valid;
    logic    r_out_recog;
    t_reason r_out_reason;
    logic    r_skid_valid;
    logic    r_skid_recog;
    t_reason r_skid_reason;
    logic    out_free;

    assign out_free = ~r_out_valid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= clear;
            end
        end else if (clear) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_recog  <= r_skid_recog;
                r_out_reason <= r_skid_reason;
            end else if (clear) begin
                r_out_recog  <= (verdict == REASON_OK);
                r_out_reason <= verdict;
            end
        end else if (clear) begin
            r_skid_recog  <= (verdict == REASON_OK);
            r_skid_reason <= verdict;
        end
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_recognized = r_out_recog;
    assign o_reason     = r_out_reason;

endmodule

`default_nettype wire

// ===== rtl/chr_checker.sv =====
`default_nettype none

module chr_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_valid,
    input wire              o_stall,
    input wire              o_valid,
    input wire              i_stall,
    input wire              o_recognized,
    input chr_pkg::t_reason o_reason
);

    import chr_pkg::*;

    // nothing waits on either side straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("verdict or stall present after reset");

    // recognised exactly when the reason says accepted
    a_recog_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_recognized == (o_reason == REASON_OK)))
        else $error("recognised flag disagrees with reason");

    // input stall only rises once a verdict has been held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without a held verdict");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_reason) && $stable(o_recognized))
        else $error("stalled verdict dropped or changed");

endmodule

bind clip_header_recognizer chr_checker u_chr_checker (.*);

`default_nettype wire
